[sv/ppmd_pkg.sv]
// shared types, constants and register codes of the ppm pulse train decoder
package ppmd_pkg;

    // channel slots decoded per frame; the index saturates here
    localparam int CHANNELS          = 16;
    // primary channels that take part in the live mask
    localparam int PRIMARY_CHANNELS  = 4;
    localparam int PRIMARY_W         = $clog2(PRIMARY_CHANNELS);

    localparam int TIME_W            = 16;
    localparam int COUNT_W           = 8;
    localparam int CHAN_W            = 5;
    localparam int CFG_IDX_W         = 2;
    localparam int CFG_DATA_W        = 16;

    localparam logic [TIME_W-1:0] SYNC_GAP_RESET  = 16'd2700;
    localparam logic [TIME_W-1:0] MIN_WIDTH_RESET = 16'd750;
    localparam logic [TIME_W-1:0] MAX_WIDTH_RESET = 16'd2250;
    localparam logic [TIME_W-1:0] FS_THRESH_RESET = 16'd975;

    localparam logic [PRIMARY_CHANNELS-1:0] MASK_FULL = '1;
    localparam logic [COUNT_W-1:0]          FS_DEC    = 8'd20;
    localparam logic [CHAN_W-1:0]           CHAN_LAST = CHAN_W'(CHANNELS);
    localparam logic [CHAN_W-1:0]           CHAN_PRIM = CHAN_W'(PRIMARY_CHANNELS);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC_GAP  = 2'd0,
        CFG_MIN_WIDTH = 2'd1,
        CFG_MAX_WIDTH = 2'd2,
        CFG_FS_THRESH = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [TIME_W-1:0] sync_gap_limit;
        logic [TIME_W-1:0] min_valid_width;
        logic [TIME_W-1:0] max_valid_width;
        logic [TIME_W-1:0] failsafe_threshold;
    } t_cfg;

    typedef struct packed {
        logic [TIME_W-1:0]  edge_time;
        logic [COUNT_W-1:0] failsafe_count;
    } t_in;

    typedef struct packed {
        logic [CHAN_W-1:0]  channel_index;
        logic [TIME_W-1:0]  pulse_width;
        logic               width_stored;
        logic               frame_sync;
        logic [COUNT_W-1:0] failsafe_count_next;
    } t_out;

endpackage

[sv/ppm_pulse_train_decoder_top.sv]
// top level of the ppm pulse train decoder: input and result registers around the datapath
// Decodes a radio ppm pulse train one falling edge per request. Each input request
// carries a 16-bit microsecond timestamp and the current external fail-safe counter;
// each produces exactly one result with the interval since the previous edge (modulo
// 2^16, the first edge measured from time 0), the channel slot it addressed, whether
// the width fell strictly inside the valid window and was stored, whether it was a
// frame sync, and the fail-safe counter after an optional saturating decrement by 20.
// The block sustains one request per clock while the result side does not stall: a
// request is captured in an input register, evaluated by a single compare/subtract
// pass against the decoder state once the result register is empty or draining, and
// written to the result register. Back-pressure from the result side only stalls the
// input when both the input and result registers are occupied. Configuration writes
// take effect on the next clock and are expected only while the block is idle.
module ppm_pulse_train_decoder_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input request channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  ppmd_pkg::t_in                   i_in_data,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output ppmd_pkg::t_out                  o_out_data,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [ppmd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ppmd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ppmd_pkg::*;

    t_cfg cfg;
    t_out res;

    // input register
    logic r_in_valid;
    t_in  r_in_data;
    logic n_in_valid;

    // result register
    logic r_out_valid;
    t_out r_out_data;
    logic n_out_valid;

    logic in_accept;
    logic advance;

    // the held request moves on when the result register is empty or draining
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_accept) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end

        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_data <= i_in_data;
        end
        if (advance) begin
            r_out_data <= res;
        end
    end

    ppmd_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // decoder state advances exactly when a request is evaluated
    ppmd_calc u_calc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_item  (r_in_data),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // stall toward the source only while a request is parked
    a_stall_parked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_out_valid && i_out_stall)
        else $error("input stalled without a parked request");

    // a frame sync restarts the index and never stores a width
    a_sync_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.frame_sync |->
            o_out_data.channel_index == '0 && !o_out_data.width_stored)
        else $error("frame sync result with nonzero index or stored width");

    // a stored width always addresses an in-range slot
    a_stored_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.width_stored |-> o_out_data.channel_index < CHAN_LAST)
        else $error("stored width on out-of-range slot");

    // an evaluated request always lands in the result register
    a_advance_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("evaluated request lost");

endmodule

[sv/ppmd_cfg_regs.sv]
// configuration register file with reset defaults
module ppmd_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ppmd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ppmd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output ppmd_pkg::t_cfg                o_cfg
);
    import ppmd_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SYNC_GAP:  n_cfg.sync_gap_limit     = i_cfg_data;
                CFG_MIN_WIDTH: n_cfg.min_valid_width    = i_cfg_data;
                CFG_MAX_WIDTH: n_cfg.max_valid_width    = i_cfg_data;
                CFG_FS_THRESH: n_cfg.failsafe_threshold = i_cfg_data;
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_gap_limit     <= SYNC_GAP_RESET;
            r_cfg.min_valid_width    <= MIN_WIDTH_RESET;
            r_cfg.max_valid_width    <= MAX_WIDTH_RESET;
            r_cfg.failsafe_threshold <= FS_THRESH_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[sv/ppmd_calc.sv]
// edge interval, channel index, live mask and fail-safe decrement
module ppmd_calc (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_step,
    input  ppmd_pkg::t_in  i_item,
    input  ppmd_pkg::t_cfg i_cfg,
    output ppmd_pkg::t_out o_res
);
    import ppmd_pkg::*;

    logic [TIME_W-1:0]           r_prev;
    logic [CHAN_W-1:0]           r_chan;
    logic [PRIMARY_CHANNELS-1:0] r_mask;

    logic [TIME_W-1:0]           n_prev;
    logic [CHAN_W-1:0]           n_chan;
    logic [PRIMARY_CHANNELS-1:0] n_mask;

    logic [TIME_W-1:0]           width;
    logic                        sync;
    logic                        in_window;
    logic                        stored;
    logic                        live;
    logic [PRIMARY_CHANNELS-1:0] mask_set;
    logic                        mask_done;
    logic [COUNT_W-1:0]          count_dec;

    always_comb begin
        width     = i_item.edge_time - r_prev;
        sync      = width > i_cfg.sync_gap_limit;
        in_window = (width > i_cfg.min_valid_width) && (width < i_cfg.max_valid_width);
        stored    = !sync && in_window && (r_chan < CHAN_LAST);
        live      = stored && (r_chan < CHAN_PRIM) && (width > i_cfg.failsafe_threshold);
        mask_set  = r_mask;
        if (live) begin
            mask_set = r_mask | (PRIMARY_CHANNELS'(1) << r_chan[PRIMARY_W-1:0]);
        end
        mask_done = stored && (mask_set == MASK_FULL);
        count_dec = (i_item.failsafe_count > FS_DEC) ? (i_item.failsafe_count - FS_DEC) : '0;

        n_prev = i_item.edge_time;
        n_mask = mask_done ? '0 : mask_set;
        if (sync) begin
            n_chan = '0;
        end else if (r_chan < CHAN_LAST) begin
            n_chan = r_chan + CHAN_W'(1);
        end else begin
            n_chan = r_chan;
        end

        o_res.channel_index       = sync ? '0 : r_chan;
        o_res.pulse_width         = width;
        o_res.width_stored        = stored;
        o_res.frame_sync          = sync;
        o_res.failsafe_count_next = mask_done ? count_dec : i_item.failsafe_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_chan <= '0;
            r_mask <= '0;
        end else if (i_step) begin
            r_prev <= n_prev;
            r_chan <= n_chan;
            r_mask <= n_mask;
        end
    end

    // index never runs past the saturation slot
    a_chan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chan <= CHAN_LAST)
        else $error("channel index beyond saturation");

    // a completed mask never survives into the next edge
    a_mask_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && mask_done |=> r_mask == '0)
        else $error("live mask not cleared after fail-safe decrement");

    // the counter only moves when the mask completes
    a_count_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.failsafe_count_next != i_item.failsafe_count |-> mask_done)
        else $error("fail-safe count changed without full mask");

endmodule

[tb/ppm_pulse_train_decoder_top_test.sv]
// self-checking testbench of the ppm pulse train decoder top level
module ppm_pulse_train_decoder_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ppmd_pkg::*;

    // generous bound: every request waiting out a full sender gap and a full result stall
    localparam int unsigned CYCLE_LIMIT = 400000;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_in                   i_in_data  = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out                  o_out_data;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    ppm_pulse_train_decoder_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // edge requests waiting for the driver, decoded results waiting for the monitor
    t_in  pending_edges[$];
    t_out decoded_due[$];

    // shadow copy of the decoder registers, only changed while the block is idle
    logic [TIME_W-1:0] cfg_sync = SYNC_GAP_RESET;
    logic [TIME_W-1:0] cfg_min  = MIN_WIDTH_RESET;
    logic [TIME_W-1:0] cfg_max  = MAX_WIDTH_RESET;
    logic [TIME_W-1:0] cfg_thr  = FS_THRESH_RESET;

    // shadow decoder state
    logic [TIME_W-1:0]           last_stamp;
    logic [CHAN_W-1:0]           chan_ptr;
    logic [PRIMARY_CHANNELS-1:0] live_mask;

    // timestamp of the most recently queued edge
    logic [TIME_W-1:0] stamp = '0;

    // percent chance per cycle of starting an idle burst on either side; 0 means none
    int unsigned idle_pct = 12;
    int unsigned send_gap;
    int unsigned stall_gap;
    int unsigned issued = 0;
    int unsigned checked = 0;
    bit          drain_hold;
    int unsigned failures = 0;
    int unsigned cycles = 0;
    t_out        want;

    // what the decoder should report for one falling edge; advances the shadow state
    function automatic t_out decode_edge(input t_in req);
        t_out              res;
        logic [TIME_W-1:0] span;
        logic [COUNT_W-1:0] count;
        res   = '0;
        span  = req.edge_time - last_stamp;
        count = req.failsafe_count;
        last_stamp = req.edge_time;
        res.channel_index = chan_ptr;
        res.pulse_width   = span;
        if (span > cfg_sync) begin
            // frame sync: index restarts, mask left alone
            res.frame_sync    = 1'b1;
            res.channel_index = '0;
            chan_ptr          = '0;
        end else begin
            if (span > cfg_min && span < cfg_max && chan_ptr < CHAN_LAST) begin
                res.width_stored = 1'b1;
                // only the primary channels feed the live mask
                if (chan_ptr < CHAN_PRIM && span > cfg_thr)
                    live_mask[chan_ptr[PRIMARY_W-1:0]] = 1'b1;
                if (live_mask == MASK_FULL) begin
                    live_mask = '0;
                    count = (count > FS_DEC) ? count - FS_DEC : '0;
                end
            end
            // index saturates one past the last slot
            if (chan_ptr < CHAN_LAST)
                chan_ptr = chan_ptr + 1'b1;
        end
        res.failsafe_count_next = count;
        return res;
    endfunction

    function automatic void compare_field(input string what, input int unsigned want_v,
                                          input int unsigned got_v);
        if (want_v != got_v) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want_v, got_v);
            failures++;
        end
    endfunction

    // request driver: holds a stalled request, otherwise idles or issues the next pending edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            last_stamp = '0;
            chan_ptr   = '0;
            live_mask  = '0;
            send_gap   = 0;
            drain_hold = 1'b0;
        end else if (!(i_in_valid && o_in_stall)) begin
            // a request went through at this edge
            if (i_in_valid)
                decoded_due.push_back(decode_edge(i_in_data));
            if (drain_hold) begin
                // sender holds off until every outstanding result is back
                if (decoded_due.size() == 0)
                    drain_hold = 1'b0;
                i_in_valid <= 1'b0;
            end else if (send_gap != 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_edges.size() != 0 && idle_pct != 0 &&
                         $urandom_range(99, 0) < idle_pct) begin
                // start an idle burst; send_gap counts the idle cycles that follow this one
                send_gap = $urandom_range(9, 0);
                i_in_valid <= 1'b0;
            end else if (pending_edges.size() != 0) begin
                i_in_data  <= pending_edges.pop_front();
                i_in_valid <= 1'b1;
                issued++;
                if (idle_pct != 0 && issued % 300 == 150)
                    drain_hold = 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result monitor: checks every accepted result and applies random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_gap = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (decoded_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual %h",
                             $time, o_out_data);
                    failures++;
                end else begin
                    want = decoded_due.pop_front();
                    checked++;
                    compare_field("channel_index", want.channel_index,
                                  o_out_data.channel_index);
                    compare_field("pulse_width", want.pulse_width, o_out_data.pulse_width);
                    compare_field("width_stored", want.width_stored,
                                  o_out_data.width_stored);
                    compare_field("frame_sync", want.frame_sync, o_out_data.frame_sync);
                    compare_field("failsafe_count_next", want.failsafe_count_next,
                                  o_out_data.failsafe_count_next);
                end
            end
            if (stall_gap != 0) begin
                stall_gap--;
                i_out_stall <= 1'b1;
            end else if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
                stall_gap = $urandom_range(9, 0);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // queue an edge at an absolute timestamp
    function automatic void queue_stamp(input logic [TIME_W-1:0] at,
                                        input logic [COUNT_W-1:0] count);
        t_in req;
        stamp              = at;
        req.edge_time      = at;
        req.failsafe_count = count;
        pending_edges.push_back(req);
    endfunction

    // queue an edge a given interval after the previous one, wrapping modulo 2^16
    function automatic void queue_edge(input logic [TIME_W-1:0] span,
                                       input logic [COUNT_W-1:0] count);
        queue_stamp(stamp + span, count);
    endfunction

    // counter values lean toward the low end so the saturating decrement gets hit
    function automatic logic [COUNT_W-1:0] fs_count();
        if ($urandom_range(1, 0) == 0)
            return COUNT_W'($urandom_range(40, 0));
        return COUNT_W'($urandom_range(255, 0));
    endfunction

    function automatic logic [TIME_W-1:0] sync_width();
        if (cfg_sync == '1)
            return TIME_W'($urandom);
        return TIME_W'($urandom_range(32'hFFFF, 32'(cfg_sync) + 1));
    endfunction

    // mostly inside the window, some on its edges, some plain noise
    function automatic logic [TIME_W-1:0] chan_width();
        int unsigned roll;
        roll = $urandom_range(99, 0);
        if (roll < 80 && 32'(cfg_max) > 32'(cfg_min) + 1)
            return TIME_W'($urandom_range(32'(cfg_max) - 1, 32'(cfg_min) + 1));
        if (roll < 90) begin
            case ($urandom_range(5, 0))
                0: return cfg_min;
                1: return cfg_min + 1'b1;
                2: return cfg_max;
                3: return cfg_max - 1'b1;
                4: return cfg_thr;
                default: return cfg_thr + 1'b1;
            endcase
        end
        return TIME_W'($urandom);
    endfunction

    // frames of sync plus channel widths; some frames run past the last slot
    function automatic void queue_frames(input int unsigned target);
        int unsigned made;
        int unsigned slots;
        made = 0;
        while (made < target) begin
            // stray edge before the sync now and then
            if ($urandom_range(19, 0) == 0) begin
                queue_edge(TIME_W'($urandom), fs_count());
                made++;
            end
            queue_edge(sync_width(), fs_count());
            made++;
            slots = ($urandom_range(4, 0) == 0) ? $urandom_range(20, 17)
                                                : $urandom_range(16, 1);
            for (int unsigned k = 0; k < slots && made < target; k++) begin
                queue_edge(chan_width(), fs_count());
                made++;
            end
        end
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input logic [TIME_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
    endtask

    // write all four registers back to back; only called while the block is idle
    task automatic load_regs(input logic [TIME_W-1:0] sync_v, input logic [TIME_W-1:0] min_v,
                             input logic [TIME_W-1:0] max_v, input logic [TIME_W-1:0] thr_v);
        cfg_sync = sync_v;
        cfg_min  = min_v;
        cfg_max  = max_v;
        cfg_thr  = thr_v;
        write_reg(CFG_SYNC_GAP, sync_v);
        write_reg(CFG_MIN_WIDTH, min_v);
        write_reg(CFG_MAX_WIDTH, max_v);
        write_reg(CFG_FS_THRESH, thr_v);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // wait until every queued request is issued and every issued one has its result back
    task automatic settle();
        while (pending_edges.size() != 0 || checked != issued)
            @(posedge i_clk);
    endtask

    initial begin
        int unsigned lo;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: first edge measured from time 0 opens a full primary set that
        // completes the live mask and knocks 20 off the counter
        queue_edge(16'd1500, 8'd255);
        queue_edge(16'd1000, 8'd0);
        queue_edge(16'd2000, 8'd20);
        queue_edge(16'd1200, 8'd21);
        // sync just above the limit, then window and threshold boundaries
        queue_edge(16'd2701, 8'd255);
        queue_edge(16'd976, 8'd19);
        queue_edge(16'd975, 8'd20);
        queue_edge(16'd751, 8'd128);
        queue_edge(16'd2249, 8'd19);
        queue_edge(16'd750, 8'd1);
        queue_edge(16'd2250, 8'd254);
        // interval equal to the sync limit is an ordinary (too wide) channel
        queue_edge(16'd2700, 8'd127);
        // repeated timestamp, zero interval
        queue_edge(16'd0, 8'd64);
        // timestamp extremes across the wrap
        queue_stamp(16'hFFFF, 8'd255);
        queue_stamp(16'h0000, 8'd0);
        queue_edge(16'd3000, 8'd20);
        queue_edge(16'd1100, 8'd20);
        queue_edge(16'd1100, 8'd20);
        queue_edge(16'd1100, 8'd20);
        queue_edge(16'd1100, 8'd20);
        queue_frames(350);
        settle();

        // widest window: nothing is ever a sync, widths other than 0 and FFFF fall in it
        idle_pct = 30;
        load_regs(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
        queue_frames(200);
        settle();

        // inverted window and zero sync limit: every nonzero interval restarts the frame
        idle_pct = 5;
        load_regs(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
        queue_frames(100);
        settle();

        // empty window with min equal to max
        load_regs(16'd3000, 16'd1500, 16'd1500, 16'd1000);
        queue_frames(100);
        settle();

        // random but sensible settings
        idle_pct = 20;
        lo = $urandom_range(1000, 0);
        load_regs(16'($urandom_range(20000, 3500)), 16'(lo),
                  16'(lo + $urandom_range(3000, 200)), 16'(lo + $urandom_range(300, 0)));
        queue_frames(300);
        settle();

        // back to power-on values, no idling on either side
        idle_pct = 0;
        load_regs(SYNC_GAP_RESET, MIN_WIDTH_RESET, MAX_WIDTH_RESET, FS_THRESH_RESET);
        queue_frames(300);
        settle();

        // let any stray result show up
        repeat (10) @(posedge i_clk);
        if (failures == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[files.f]
sv/ppmd_pkg.sv
sv/ppmd_cfg_regs.sv
sv/ppmd_calc.sv
sv/ppm_pulse_train_decoder_top.sv
tb/ppm_pulse_train_decoder_top_test.sv
